### hdl/w3de_pkg.sv
// ============================================================================
// w3de_pkg
// Shared types, constants and address helpers for the weighted 3D
// dilate / erode block.
// ============================================================================
package w3de_pkg;

    // Store geometry
    localparam int MAX_SIDE  = 64;
    localparam int MAX_KSIDE = 7;

    // Fixed field widths
    localparam int POS_W      = 6;
    localparam int VOX_W      = 16;
    localparam int WGT_W      = 10;
    localparam int OUT_W      = 17;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_REG_W = 7;
    localparam int KERN_REG_W = 3;
    localparam int FRAC_W     = 8;

    // Derived widths
    localparam int SZ_W      = $clog2(MAX_SIDE + 1);
    localparam int KSZ_W     = $clog2(MAX_KSIDE + 1);
    localparam int KIDX_W    = (MAX_KSIDE > 1) ? $clog2(MAX_KSIDE) : 1;
    localparam int CRD_W     = (POS_W > SZ_W) ? POS_W : SZ_W;
    localparam int NC_W      = CRD_W + 2;
    localparam int VOL_DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int KER_DEPTH = MAX_KSIDE * MAX_KSIDE * MAX_KSIDE;
    localparam int VA_W      = $clog2(VOL_DEPTH);
    localparam int KA_W      = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
    localparam int PROD_W    = VOX_W + WGT_W;
    localparam int ACC_W     = PROD_W - FRAC_W;

    // Output saturation limits
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(2 ** (OUT_W - 1)));

    // Register reset values
    localparam logic [SIZE_REG_W-1:0] SIZE_X_RST    = SIZE_REG_W'(64);
    localparam logic [SIZE_REG_W-1:0] SIZE_Y_RST    = SIZE_REG_W'(64);
    localparam logic [SIZE_REG_W-1:0] SIZE_Z_RST    = SIZE_REG_W'(1);
    localparam logic [KERN_REG_W-1:0] KERN_X_RST    = KERN_REG_W'(3);
    localparam logic [KERN_REG_W-1:0] KERN_Y_RST    = KERN_REG_W'(3);
    localparam logic [KERN_REG_W-1:0] KERN_Z_RST    = KERN_REG_W'(1);
    localparam logic                  DO_DILATE_RST = 1'b1;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_KERN  = 2'd0,
        FUNC_VOXEL = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X    = 3'd0,
        CFG_SIZE_Y    = 3'd1,
        CFG_SIZE_Z    = 3'd2,
        CFG_KERN_X    = 3'd3,
        CFG_KERN_Y    = 3'd4,
        CFG_KERN_Z    = 3'd5,
        CFG_DO_DILATE = 3'd6
    } cfg_idx_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic wr_kern;
        logic wr_vox;
        logic load;
        logic step;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_volume;
        logic last;
        logic out_free;
    } stat_t;

    // Linear voxel address, x fastest
    function automatic logic [VA_W-1:0] vol_addr(
        input logic [CRD_W-1:0] x,
        input logic [CRD_W-1:0] y,
        input logic [CRD_W-1:0] z
    );
        return VA_W'(x) + VA_W'(y) * VA_W'(MAX_SIDE)
             + VA_W'(z) * VA_W'(MAX_SIDE * MAX_SIDE);
    endfunction

    // Linear kernel address, x fastest
    function automatic logic [KA_W-1:0] kern_addr(
        input logic [CRD_W-1:0] x,
        input logic [CRD_W-1:0] y,
        input logic [CRD_W-1:0] z
    );
        return KA_W'(x) + KA_W'(y) * KA_W'(MAX_KSIDE)
             + KA_W'(z) * KA_W'(MAX_KSIDE * MAX_KSIDE);
    endfunction

endpackage

### hdl/w3de_ram.sv
// ============================================================================
// w3de_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
module w3de_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/w3de_ctrl.sv
// ============================================================================
// w3de_ctrl
// Sequencer: accepts items, walks the kernel for a query and hands the
// result to the output register.
// ============================================================================
module w3de_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        func,
    output logic              in_ready,
    input  w3de_pkg::stat_t   status,
    output w3de_pkg::cmd_t    cmd
);

    w3de_pkg::state_t state_reg;
    w3de_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= w3de_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            w3de_pkg::ST_IDLE:
            begin
                if (in_valid && (func == w3de_pkg::FUNC_QUERY))
                begin
                    state_next = w3de_pkg::ST_LOAD;
                end
            end
            w3de_pkg::ST_LOAD:
            begin
                state_next = status.in_volume ? w3de_pkg::ST_WALK : w3de_pkg::ST_FINISH;
            end
            w3de_pkg::ST_WALK:
            begin
                if (status.last)
                begin
                    state_next = w3de_pkg::ST_DRAIN1;
                end
            end
            w3de_pkg::ST_DRAIN1:
            begin
                state_next = w3de_pkg::ST_DRAIN2;
            end
            w3de_pkg::ST_DRAIN2:
            begin
                state_next = w3de_pkg::ST_FINISH;
            end
            w3de_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = w3de_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = w3de_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            w3de_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid && (func == w3de_pkg::FUNC_QUERY);
                cmd.wr_kern = in_valid && (func == w3de_pkg::FUNC_KERN);
                cmd.wr_vox  = in_valid && (func == w3de_pkg::FUNC_VOXEL);
            end
            w3de_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            w3de_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
            end
            w3de_pkg::ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A query item leads straight into the center read
    a_query_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (func == w3de_pkg::FUNC_QUERY))
            |=> (state_reg == w3de_pkg::ST_LOAD))
        else $error("query accepted without load");

    // A finished result waits while the output slot is taken
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == w3de_pkg::ST_FINISH) && !status.out_free)
            |=> (state_reg == w3de_pkg::ST_FINISH))
        else $error("finished result dropped");

    // A query outside the volume skips the kernel walk
    a_outside_skips: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == w3de_pkg::ST_LOAD) && !status.in_volume)
            |=> (state_reg == w3de_pkg::ST_FINISH))
        else $error("outside query walked kernel");

endmodule

### hdl/w3de_dp.sv
// ============================================================================
// w3de_dp
// Datapath: configuration registers, volume and kernel memories, kernel
// walk counters, weight multiply, max/min accumulate and output register.
// ============================================================================
module w3de_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [w3de_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [w3de_pkg::CFG_W-1:0]          cfg_data,
    // input payload
    input  logic [w3de_pkg::POS_W-1:0]          pos_x,
    input  logic [w3de_pkg::POS_W-1:0]          pos_y,
    input  logic [w3de_pkg::POS_W-1:0]          pos_z,
    input  logic signed [w3de_pkg::VOX_W-1:0]   voxel_value,
    input  logic signed [w3de_pkg::WGT_W-1:0]   weight,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [w3de_pkg::OUT_W-1:0]   morph_value,
    output logic                                clipped,
    // control
    input  w3de_pkg::cmd_t                      cmd,
    output w3de_pkg::stat_t                     status
);

    localparam int SZ_W   = w3de_pkg::SZ_W;
    localparam int KSZ_W  = w3de_pkg::KSZ_W;
    localparam int KIDX_W = w3de_pkg::KIDX_W;
    localparam int CRD_W  = w3de_pkg::CRD_W;
    localparam int NC_W   = w3de_pkg::NC_W;
    localparam int ACC_W  = w3de_pkg::ACC_W;

    // Size clamps: volume sides 1..MAX_SIDE, kernel sides 0..MAX_KSIDE
    function automatic logic [SZ_W-1:0] clamp_side(
        input logic [w3de_pkg::SIZE_REG_W-1:0] v
    );
        if (v == '0)
        begin
            return SZ_W'(1);
        end
        else if (int'(v) > w3de_pkg::MAX_SIDE)
        begin
            return SZ_W'(w3de_pkg::MAX_SIDE);
        end
        return SZ_W'(v);
    endfunction

    function automatic logic [KSZ_W-1:0] clamp_kside(
        input logic [w3de_pkg::KERN_REG_W-1:0] v
    );
        if (int'(v) > w3de_pkg::MAX_KSIDE)
        begin
            return KSZ_W'(w3de_pkg::MAX_KSIDE);
        end
        return KSZ_W'(v);
    endfunction

    // Configuration registers
    logic [w3de_pkg::SIZE_REG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [w3de_pkg::KERN_REG_W-1:0] kern_x_reg, kern_y_reg, kern_z_reg;
    logic                            do_dilate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= w3de_pkg::SIZE_X_RST;
            size_y_reg    <= w3de_pkg::SIZE_Y_RST;
            size_z_reg    <= w3de_pkg::SIZE_Z_RST;
            kern_x_reg    <= w3de_pkg::KERN_X_RST;
            kern_y_reg    <= w3de_pkg::KERN_Y_RST;
            kern_z_reg    <= w3de_pkg::KERN_Z_RST;
            do_dilate_reg <= w3de_pkg::DO_DILATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                w3de_pkg::CFG_SIZE_X:    size_x_reg    <= cfg_data[w3de_pkg::SIZE_REG_W-1:0];
                w3de_pkg::CFG_SIZE_Y:    size_y_reg    <= cfg_data[w3de_pkg::SIZE_REG_W-1:0];
                w3de_pkg::CFG_SIZE_Z:    size_z_reg    <= cfg_data[w3de_pkg::SIZE_REG_W-1:0];
                w3de_pkg::CFG_KERN_X:    kern_x_reg    <= cfg_data[w3de_pkg::KERN_REG_W-1:0];
                w3de_pkg::CFG_KERN_Y:    kern_y_reg    <= cfg_data[w3de_pkg::KERN_REG_W-1:0];
                w3de_pkg::CFG_KERN_Z:    kern_z_reg    <= cfg_data[w3de_pkg::KERN_REG_W-1:0];
                w3de_pkg::CFG_DO_DILATE: do_dilate_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective sizes
    logic [SZ_W-1:0]  sx, sy, sz;
    logic [KSZ_W-1:0] kx, ky, kz;
    logic             kern_nonempty;

    always_comb
    begin
        sx = clamp_side(size_x_reg);
        sy = clamp_side(size_y_reg);
        sz = clamp_side(size_z_reg);
        kx = clamp_kside(kern_x_reg);
        ky = clamp_kside(kern_y_reg);
        kz = clamp_kside(kern_z_reg);
        kern_nonempty = (kx != '0) && (ky != '0) && (kz != '0);
    end

    // Write address decode for store writes
    logic                          vox_wr_ok, kern_wr_ok;
    logic [w3de_pkg::VA_W-1:0]     vox_waddr;
    logic [w3de_pkg::KA_W-1:0]     kern_waddr;

    always_comb
    begin
        vox_wr_ok  = (int'(pos_x) < w3de_pkg::MAX_SIDE) && (int'(pos_y) < w3de_pkg::MAX_SIDE)
                  && (int'(pos_z) < w3de_pkg::MAX_SIDE);
        kern_wr_ok = (int'(pos_x) < w3de_pkg::MAX_KSIDE) && (int'(pos_y) < w3de_pkg::MAX_KSIDE)
                  && (int'(pos_z) < w3de_pkg::MAX_KSIDE);
        vox_waddr  = w3de_pkg::vol_addr(CRD_W'(pos_x), CRD_W'(pos_y), CRD_W'(pos_z));
        kern_waddr = w3de_pkg::kern_addr(CRD_W'(pos_x), CRD_W'(pos_y), CRD_W'(pos_z));
    end

    // Query position
    logic [w3de_pkg::POS_W-1:0] q_x_reg, q_y_reg, q_z_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            q_x_reg <= pos_x;
            q_y_reg <= pos_y;
            q_z_reg <= pos_z;
        end
    end

    // Kernel walk counters, third axis fastest
    logic [KIDX_W-1:0] i_reg, j_reg, k_reg;
    logic              i_last, j_last, k_last;

    always_comb
    begin
        i_last = (KSZ_W'(i_reg) == (kx - KSZ_W'(1)));
        j_last = (KSZ_W'(j_reg) == (ky - KSZ_W'(1)));
        k_last = (KSZ_W'(k_reg) == (kz - KSZ_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.load)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (k_last)
            begin
                k_reg <= '0;
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + KIDX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + KIDX_W'(1);
                end
            end
            else
            begin
                k_reg <= k_reg + KIDX_W'(1);
            end
        end
    end

    // Neighbor coordinates and bounds
    logic signed [NC_W-1:0] nx, ny, nz;
    logic                   nb_inside;
    logic                   q_inside;

    always_comb
    begin
        nx = signed'(NC_W'(q_x_reg)) - signed'(NC_W'(kx >> 1)) + signed'(NC_W'(i_reg));
        ny = signed'(NC_W'(q_y_reg)) - signed'(NC_W'(ky >> 1)) + signed'(NC_W'(j_reg));
        nz = signed'(NC_W'(q_z_reg)) - signed'(NC_W'(kz >> 1)) + signed'(NC_W'(k_reg));
        nb_inside = (nx >= 0) && (nx < signed'(NC_W'(sx)))
                 && (ny >= 0) && (ny < signed'(NC_W'(sy)))
                 && (nz >= 0) && (nz < signed'(NC_W'(sz)));
        q_inside  = (CRD_W'(q_x_reg) < CRD_W'(sx)) && (CRD_W'(q_y_reg) < CRD_W'(sy))
                 && (CRD_W'(q_z_reg) < CRD_W'(sz));
    end

    // Read addresses: center voxel on load, neighbor while walking
    logic [w3de_pkg::VA_W-1:0]        vox_raddr;
    logic [w3de_pkg::KA_W-1:0]        kern_raddr;
    logic signed [w3de_pkg::VOX_W-1:0] vox_rdata;
    logic signed [w3de_pkg::WGT_W-1:0] kern_rdata;

    always_comb
    begin
        if (cmd.load)
        begin
            vox_raddr = w3de_pkg::vol_addr(CRD_W'(q_x_reg), CRD_W'(q_y_reg), CRD_W'(q_z_reg));
        end
        else
        begin
            vox_raddr = w3de_pkg::vol_addr(nx[CRD_W-1:0], ny[CRD_W-1:0], nz[CRD_W-1:0]);
        end
        kern_raddr = w3de_pkg::kern_addr(CRD_W'(i_reg), CRD_W'(j_reg), CRD_W'(k_reg));
    end

    w3de_ram #(
        .WIDTH (w3de_pkg::VOX_W),
        .DEPTH (w3de_pkg::VOL_DEPTH)
    ) u_vol_ram (
        .clk   (clk),
        .we    (cmd.wr_vox && vox_wr_ok),
        .waddr (vox_waddr),
        .wdata (voxel_value),
        .re    (cmd.load || cmd.step),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    w3de_ram #(
        .WIDTH (w3de_pkg::WGT_W),
        .DEPTH (w3de_pkg::KER_DEPTH)
    ) u_kern_ram (
        .clk   (clk),
        .we    (cmd.wr_kern && kern_wr_ok),
        .waddr (kern_waddr),
        .wdata (weight),
        .re    (cmd.step),
        .raddr (kern_raddr),
        .rdata (kern_rdata)
    );

    // Pipeline tags: read, multiply, accumulate
    logic center_pend_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_pend_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            center_pend_reg <= cmd.load;
            s1_valid_reg    <= cmd.step && kern_nonempty && nb_inside;
            s2_valid_reg    <= s1_valid_reg && (kern_rdata != '0);
        end
    end

    // Weight times neighbor
    logic signed [w3de_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= kern_rdata * vox_rdata;
    end

    // Scaled product (floor divide by 256) and max/min accumulate
    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    take;

    always_comb
    begin
        scaled = signed'(prod_reg[w3de_pkg::PROD_W-1:w3de_pkg::FRAC_W]);
        take   = do_dilate_reg ? (scaled > acc_reg) : (scaled < acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (center_pend_reg)
        begin
            acc_reg <= ACC_W'(vox_rdata);
        end
        else if (s2_valid_reg && take)
        begin
            acc_reg <= scaled;
        end
    end

    // Saturation
    logic signed [ACC_W-1:0] sat_val;
    logic                    sat_clip;

    always_comb
    begin
        priority if (acc_reg > w3de_pkg::OUT_MAX)
        begin
            sat_val  = w3de_pkg::OUT_MAX;
            sat_clip = 1'b1;
        end
        else if (acc_reg < w3de_pkg::OUT_MIN)
        begin
            sat_val  = w3de_pkg::OUT_MIN;
            sat_clip = 1'b1;
        end
        else
        begin
            sat_val  = acc_reg;
            sat_clip = 1'b0;
        end
    end

    // Output register
    logic                                out_valid_reg;
    logic signed [w3de_pkg::OUT_W-1:0]   morph_reg;
    logic                                clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            morph_reg   <= q_inside ? sat_val[w3de_pkg::OUT_W-1:0] : '0;
            clipped_reg <= q_inside && sat_clip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign morph_value = morph_reg;
    assign clipped     = clipped_reg;

    // Status
    always_comb
    begin
        status.in_volume = q_inside;
        status.last      = !kern_nonempty || (i_last && j_last && k_last);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");

    // The walk starts with an empty pipeline
    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("pipeline busy at query start");

    // Center load never collides with an accumulate
    a_center_alone: assert property (@(posedge clk) disable iff (!rst_n)
        center_pend_reg |-> !s2_valid_reg)
        else $error("center load collides with accumulate");

endmodule

### hdl/weighted_3d_dilate_erode_top.sv
// ============================================================================
// weighted_3d_dilate_erode_top
// Grayscale 3D dilation / erosion with a weighted structuring element.
// ============================================================================
// Usage:
//   The input channel (in_valid / in_ready) carries one item per handshake:
//   a kernel weight write, a voxel write, or a voxel query. Writes stream at
//   one item per clock while no query is in progress. A query reads the
//   center voxel, then walks all N = kern_x*kern_y*kern_z kernel entries
//   through the volume and kernel memory read ports, one entry per cycle,
//   followed by a two-stage multiply / accumulate drain (N counts as 1 for
//   an empty element); a query outside the volume skips the walk. No new
//   item is accepted until the result has moved to the output register.
//   The result sits in an output register; writes keep flowing while it
//   waits. A finished query waits for the slot while out_ready is low.
//   Reset sets the configuration registers to their defaults and empties
//   the pipeline; memory contents are undefined until written.
//   The user must write configuration (cfg_we / cfg_index / cfg_data) only
//   when idle; the block itself does not enforce this.
// ============================================================================
module weighted_3d_dilate_erode_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [w3de_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [w3de_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [w3de_pkg::POS_W-1:0]          pos_x,
    input  logic [w3de_pkg::POS_W-1:0]          pos_y,
    input  logic [w3de_pkg::POS_W-1:0]          pos_z,
    input  logic signed [w3de_pkg::VOX_W-1:0]   voxel_value,
    input  logic signed [w3de_pkg::WGT_W-1:0]   weight,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [w3de_pkg::OUT_W-1:0]   morph_value,
    output logic                                clipped
);

    w3de_pkg::cmd_t  cmd;
    w3de_pkg::stat_t status;

    // Sequencer
    w3de_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    w3de_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .voxel_value (voxel_value),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .morph_value (morph_value),
        .clipped     (clipped),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted 3D dilate / erode block. Kernel, voxel
// and query items go in under random valid/ready gaps. A scoreboard keeps its
// own volume, kernel and register copies, works out each query's result and
// compares it field by field with the output channel, oldest first.
// ----------------------------------------------------------------------------
module tb;
    import w3de_pkg::*;

    localparam logic [1:0]           FUNC_NONE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
    localparam int                   MORPH_HI       = (1 << (OUT_W - 1)) - 1;
    localparam int                   MORPH_LO       = -(1 << (OUT_W - 1));
    localparam int                   SIZE_REG_MAX   = (1 << SIZE_REG_W) - 1;
    localparam int                   ITEM_TARGET    = 1900;
    localparam int                   QUIET_AFTER    = ITEM_TARGET - 200;
    localparam int                   SETTLE_CYCLES  = KER_DEPTH + 16;
    localparam int                   WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             clip;
    } morph_t;

    // Scoreboard: mirrors both stores and the registers, queues query results
    class morph_checker;
        logic signed [VOX_W-1:0]  voxels [VOL_DEPTH];
        logic signed [WGT_W-1:0]  weights [KER_DEPTH];
        logic [SIZE_REG_W-1:0]    size_reg [3];
        logic [KERN_REG_W-1:0]    kern_reg [3];
        logic                     dilate;
        morph_t                   pending_morph [$];
        int                       fails;

        function new();
            size_reg[0] = SIZE_X_RST;
            size_reg[1] = SIZE_Y_RST;
            size_reg[2] = SIZE_Z_RST;
            kern_reg[0] = KERN_X_RST;
            kern_reg[1] = KERN_Y_RST;
            kern_reg[2] = KERN_Z_RST;
            dilate      = DO_DILATE_RST;
            fails       = 0;
        endfunction

        // zero acts as one, anything past the store acts as the store side
        function int side(int a);
            if (size_reg[a] == 0)
                return 1;
            if (size_reg[a] > MAX_SIDE)
                return MAX_SIDE;
            return int'(size_reg[a]);
        endfunction

        function int kside(int a);
            return (kern_reg[a] > MAX_KSIDE) ? MAX_KSIDE : int'(kern_reg[a]);
        endfunction

        function int vox_index(int x, int y, int z);
            return x + y * MAX_SIDE + z * MAX_SIDE * MAX_SIDE;
        endfunction

        function int wgt_index(int x, int y, int z);
            return x + y * MAX_KSIDE + z * MAX_KSIDE * MAX_KSIDE;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SIZE_X:    size_reg[0] = data[SIZE_REG_W-1:0];
                CFG_SIZE_Y:    size_reg[1] = data[SIZE_REG_W-1:0];
                CFG_SIZE_Z:    size_reg[2] = data[SIZE_REG_W-1:0];
                CFG_KERN_X:    kern_reg[0] = data[KERN_REG_W-1:0];
                CFG_KERN_Y:    kern_reg[1] = data[KERN_REG_W-1:0];
                CFG_KERN_Z:    kern_reg[2] = data[KERN_REG_W-1:0];
                CFG_DO_DILATE: dilate      = data[0];
                default:       ;
            endcase
        endfunction

        // Weighted max / min over the window around one voxel
        function morph_t morph_of_voxel(int x, int y, int z);
            int     sx, sy, sz, kx, ky, kz, acc, i, j, k, nx, ny, nz, w, p;
            morph_t r;
            sx = side(0);
            sy = side(1);
            sz = side(2);
            kx = kside(0);
            ky = kside(1);
            kz = kside(2);
            r  = '0;
            if (x >= sx || y >= sy || z >= sz)
            begin
                return r;
            end
            acc = voxels[vox_index(x, y, z)];
            for (i = 0; i < kx; i++)
            begin
                for (j = 0; j < ky; j++)
                begin
                    for (k = 0; k < kz; k++)
                    begin
                        nx = x - kx / 2 + i;
                        ny = y - ky / 2 + j;
                        nz = z - kz / 2 + k;
                        if (nx < 0 || nx >= sx || ny < 0 || ny >= sy || nz < 0 || nz >= sz)
                            continue;
                        w = weights[wgt_index(i, j, k)];
                        if (w == 0)
                            continue;
                        p = (w * voxels[vox_index(nx, ny, nz)]) >>> FRAC_W;
                        if (dilate ? (p > acc) : (p < acc))
                            acc = p;
                    end
                end
            end
            if (acc > MORPH_HI)
            begin
                acc    = MORPH_HI;
                r.clip = 1'b1;
            end
            if (acc < MORPH_LO)
            begin
                acc    = MORPH_LO;
                r.clip = 1'b1;
            end
            r.value = acc[OUT_W-1:0];
            return r;
        endfunction

        // Returns 0 when the block drops the item
        function bit note_item(logic [1:0] f, int x, int y, int z,
                               logic signed [VOX_W-1:0] vox, logic signed [WGT_W-1:0] wgt);
            case (f)
                FUNC_KERN:
                begin
                    if (x >= MAX_KSIDE || y >= MAX_KSIDE || z >= MAX_KSIDE)
                    begin
                        return 1'b0;
                    end
                    weights[wgt_index(x, y, z)] = wgt;
                end
                FUNC_VOXEL: voxels[vox_index(x, y, z)] = vox;
                FUNC_QUERY: pending_morph.push_back(morph_of_voxel(x, y, z));
                default:    return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void check_result(logic [OUT_W-1:0] value, logic clip);
            morph_t want;
            if (pending_morph.size() == 0)
            begin
                $error("result with no query pending: morph_value %0d", $signed(value));
                fails++;
                return;
            end
            want = pending_morph.pop_front();
            if (value !== want.value)
            begin
                $error("morph_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(value));
                fails++;
            end
            if (clip !== want.clip)
            begin
                $error("clipped: expected %0b, actual %0b", want.clip, clip);
                fails++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              func;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;
    logic signed [VOX_W-1:0] voxel_value;
    logic signed [WGT_W-1:0] weight;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] morph_value;
    logic                    clipped;

    morph_checker board;
    bit           vox_seen [VOL_DEPTH];
    bit           wgt_seen [KER_DEPTH];
    int           items_sent;
    bit           in_gaps_on;
    bit           out_stalls_on;
    bit           quiet_tail;
    int           hold_left;
    int           idle_cycles;
    int           tap_weights [9] = '{-512, 511, 0, 1, -1, 256, -256, 0, 3};

    weighted_3d_dilate_erode_top dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: random stall bursts on out_ready
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (out_stalls_on && !quiet_tail && $urandom_range(0, 7) == 0)
        begin
            hold_left <= $urandom_range(1, 8);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(morph_value, clipped);
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [VOX_W-1:0] rand_voxel();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VOX_W - 1){1'b0}}};
            1:       return {1'b0, {(VOX_W - 1){1'b1}}};
            default: return VOX_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [WGT_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return {1'b1, {(WGT_W - 1){1'b0}}};
            3:       return {1'b0, {(WGT_W - 1){1'b1}}};
            default: return WGT_W'($urandom);
        endcase
    endfunction

    // Small sides anywhere; large sides only near their ends so writes get reused
    function automatic int pick_coord(int side_len);
        if (side_len <= 8)
            return $urandom_range(0, side_len - 1);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return side_len - 2;
            default: return side_len - 1;
        endcase
    endfunction

    // Register value with random junk above its width
    function automatic logic [CFG_W-1:0] pad_reg(int val, int width);
        logic [CFG_W-1:0] r;
        int               b;
        r = ($urandom_range(0, 1) == 0) ? '0 : CFG_W'($urandom);
        for (b = 0; b < width; b++)
            r[b] = val[b];
        return r;
    endfunction

    task automatic send_item(logic [1:0] f, int x, int y, int z,
                             logic signed [VOX_W-1:0] vox, logic signed [WGT_W-1:0] wgt);
        int gap;
        if (in_gaps_on && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        pos_x       <= x[POS_W-1:0];
        pos_y       <= y[POS_W-1:0];
        pos_z       <= z[POS_W-1:0];
        voxel_value <= vox;
        weight      <= wgt;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (board.note_item(f, x, y, z, vox, wgt))
        begin
            items_sent++;
            if (f == FUNC_KERN)
                wgt_seen[board.wgt_index(x, y, z)] = 1'b1;
            if (f == FUNC_VOXEL)
                vox_seen[board.vox_index(x, y, z)] = 1'b1;
        end
        if (items_sent >= QUIET_AFTER)
            quiet_tail = 1'b1;
    endtask

    // Query one voxel, first filling any voxel or weight the window would read
    task automatic query_at(int x, int y, int z);
        int sx, sy, sz, kx, ky, kz, i, j, k, nx, ny, nz;
        sx = board.side(0);
        sy = board.side(1);
        sz = board.side(2);
        kx = board.kside(0);
        ky = board.kside(1);
        kz = board.kside(2);
        if (x < sx && y < sy && z < sz)
        begin
            if (!vox_seen[board.vox_index(x, y, z)])
                send_item(FUNC_VOXEL, x, y, z, rand_voxel(), rand_weight());
            for (i = 0; i < kx; i++)
            begin
                for (j = 0; j < ky; j++)
                begin
                    for (k = 0; k < kz; k++)
                    begin
                        nx = x - kx / 2 + i;
                        ny = y - ky / 2 + j;
                        nz = z - kz / 2 + k;
                        if (nx < 0 || nx >= sx || ny < 0 || ny >= sy || nz < 0 || nz >= sz)
                            continue;
                        if (!wgt_seen[board.wgt_index(i, j, k)])
                            send_item(FUNC_KERN, i, j, k, rand_voxel(), rand_weight());
                        if (!vox_seen[board.vox_index(nx, ny, nz)])
                            send_item(FUNC_VOXEL, nx, ny, nz, rand_voxel(), rand_weight());
                    end
                end
            end
        end
        send_item(FUNC_QUERY, x, y, z, rand_voxel(), rand_weight());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic configure(int sx, int sy, int sz, int kx, int ky, int kz, int dil);
        write_reg(CFG_SIZE_X, sx[CFG_W-1:0]);
        write_reg(CFG_SIZE_Y, sy[CFG_W-1:0]);
        write_reg(CFG_SIZE_Z, sz[CFG_W-1:0]);
        write_reg(CFG_KERN_X, pad_reg(kx, KERN_REG_W));
        write_reg(CFG_KERN_Y, pad_reg(ky, KERN_REG_W));
        write_reg(CFG_KERN_Z, pad_reg(kz, KERN_REG_W));
        write_reg(CFG_DO_DILATE, pad_reg(dil, 1));
        // index past the register list must change nothing
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Stop sending, wait out every pending query plus the longest walk
    task automatic drain_idle();
        in_valid <= 1'b0;
        while (board.pending_morph.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_action();
        int roll, sx, sy, sz;
        roll = $urandom_range(0, 99);
        sx   = board.side(0);
        sy   = board.side(1);
        sz   = board.side(2);
        if (roll < 45)
            query_at(pick_coord(sx), pick_coord(sy), pick_coord(sz));
        else if (roll < 52)
            query_at($urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                     $urandom_range(0, MAX_SIDE - 1));
        else if (roll < 75)
            send_item(FUNC_VOXEL, pick_coord(sx), pick_coord(sy), pick_coord(sz),
                      rand_voxel(), rand_weight());
        else if (roll < 82)
            send_item(FUNC_VOXEL, $urandom_range(0, MAX_SIDE - 1),
                      $urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                      rand_voxel(), rand_weight());
        else if (roll < 95)
            // coordinate MAX_KSIDE falls outside the kernel store
            send_item(FUNC_KERN, $urandom_range(0, MAX_KSIDE), $urandom_range(0, MAX_KSIDE),
                      $urandom_range(0, MAX_KSIDE), rand_voxel(), rand_weight());
        else
            send_item(FUNC_NONE, $urandom_range(0, MAX_SIDE - 1),
                      $urandom_range(0, MAX_SIDE - 1), $urandom_range(0, MAX_SIDE - 1),
                      rand_voxel(), rand_weight());
    endtask

    task automatic run_phase(int sx, int sy, int sz, int kx, int ky, int kz, int dil,
                             int actions);
        drain_idle();
        configure(sx, sy, sz, kx, ky, kz, dil);
        in_gaps_on    = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
        repeat (actions)
        begin
            if (items_sent < ITEM_TARGET)
                random_action();
        end
    endtask

    // Mostly small volumes and kernels, now and then the register extremes
    task automatic random_phase();
        int sizes [3];
        int kerns [3];
        int a;
        for (a = 0; a < 3; a++)
        begin
            case ($urandom_range(0, 9))
                0:       sizes[a] = 0;
                1:       sizes[a] = $urandom_range(MAX_SIDE, SIZE_REG_MAX);
                default: sizes[a] = $urandom_range(1, 8);
            endcase
            kerns[a] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_KSIDE)
                                                   : $urandom_range(1, 3);
        end
        run_phase(sizes[0], sizes[1], sizes[2], kerns[0], kerns[1], kerns[2],
                  $urandom_range(0, 1), $urandom_range(30, 90));
    endtask

    initial
    begin
        int n;
        board         = new();
        items_sent    = 0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        quiet_tail    = 1'b0;
        hold_left     = 0;
        idle_cycles   = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_KERN;
        pos_x         <= '0;
        pos_y         <= '0;
        pos_z         <= '0;
        voxel_value   <= '0;
        weight        <= '0;
        out_ready     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 64x64 image, 3x3 element, dilation.
        // Ignored items first: unused function code, kernel write off the store.
        send_item(FUNC_NONE, 21, 42, 63, rand_voxel(), rand_weight());
        send_item(FUNC_KERN, MAX_KSIDE, 0, MAX_KSIDE - 1, rand_voxel(), 10'sd5);
        for (n = 0; n < 9; n++)
            send_item(FUNC_KERN, n % 3, n / 3, 0, rand_voxel(), WGT_W'(tap_weights[n]));
        send_item(FUNC_VOXEL, 0, 0, 0, 16'sh8000, rand_weight());
        send_item(FUNC_VOXEL, 1, 1, 0, 16'sd32767, rand_weight());
        send_item(FUNC_VOXEL, 2, 2, 0, 16'sh8000, rand_weight());
        send_item(FUNC_VOXEL, 63, 63, 0, 16'sd32767, rand_weight());
        // most negative weight on most negative voxel saturates the maximum
        query_at(1, 1, 0);
        query_at(0, 0, 0);
        query_at(63, 63, 0);
        query_at(63, 0, 0);
        // beyond size_z of a 2D image
        query_at(5, 5, 1);

        // same data, erosion
        drain_idle();
        configure(MAX_SIDE, MAX_SIDE, 1, 3, 3, 1, 0);
        query_at(1, 1, 0);
        query_at(2, 2, 0);

        // full volume with the largest element, at opposite corners
        drain_idle();
        configure(MAX_SIDE, MAX_SIDE, MAX_SIDE, MAX_KSIDE, MAX_KSIDE, MAX_KSIDE, 1);
        query_at(0, 0, 0);
        query_at(63, 63, 63);

        // zero sizes act as one, oversize as the store side, zero kernel is empty
        run_phase(0, SIZE_REG_MAX, 1, 0, MAX_KSIDE, 1, 0, 25);
        run_phase(SIZE_REG_MAX, 0, SIZE_REG_MAX, MAX_KSIDE, 0, MAX_KSIDE, 1, 25);
        run_phase(1, 1, 1, 1, 1, 1, 0, 10);

        while (items_sent < ITEM_TARGET)
            random_phase();

        drain_idle();
        if (board.fails == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
